@@ rtl/inrl_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helpers of the iNES NROM SRAM loader.
// Used by every module of the loader; depends on nothing else.
package inrl_pkg;

	localparam int unsigned PRG_BYTES = 32768;
	localparam int unsigned CHR_BYTES = 8192;
	localparam int unsigned BANK_PRG = 16384;
	localparam int unsigned BANK_CHR = 8192;
	localparam int unsigned TRAINER_LEN = 512;
	localparam int unsigned HEADER_LEN = 16;
	localparam int unsigned ADDR_W = 15;
	localparam int unsigned CNT_W = 15;
	localparam int unsigned CMD_DEPTH = 4;

	localparam int unsigned PRG_MAX_BANKS = PRG_BYTES / BANK_PRG;
	localparam int unsigned CHR_MAX_BANKS = CHR_BYTES / BANK_CHR;
	localparam bit PRG_MIRROR = (PRG_BYTES > BANK_PRG);
	localparam logic [7:0] TRAINER_FLAG = 8'h04;

	localparam logic RK_WRITE = 1'b0;
	localparam logic RK_STATUS = 1'b1;
	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_END = 1'b1;
	localparam logic TGT_PRG = 1'b0;
	localparam logic TGT_CHR = 1'b1;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_TRAINER,
		PH_PRG,
		PH_CHR,
		PH_TAIL,
		PH_REJECTED
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_BAD_HEADER,
		ST_NOT_NROM,
		ST_TRUNCATED
	} load_status_t;

	typedef enum logic [1:0] {
		OP_WRITE,
		OP_MIRROR,
		OP_STATUS
	} cmd_op_t;

	typedef struct packed {
		logic kind;
		logic [7:0] image_byte;
	} in_item_t;

	typedef struct packed {
		logic result_kind;
		logic target;
		logic [ADDR_W-1:0] address;
		logic [7:0] write_data;
		load_status_t status;
		logic last;
	} out_item_t;

	typedef struct packed {
		cmd_op_t op;
		logic target;
		logic [ADDR_W-1:0] address;
		logic [7:0] data;
		load_status_t status;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_req_t;

	function automatic logic [7:0] magic_byte(input logic [1:0] idx);
		logic [7:0] m;
		unique case (idx)
			2'd0: m = 8'h4E;
			2'd1: m = 8'h45;
			2'd2: m = 8'h53;
			default: m = 8'h1A;
		endcase
		return m;
	endfunction

endpackage

@@ rtl/ines_nrom_sram_loader.sv @@
`timescale 1ns / 1ps
// A taken item's command is registered in the command queue, and its result then in
// the result register of the write sequencer. Throughput: one image byte per cycle
// while the command queue is not full; a mirrored PRG byte yields two results, which
// the write sequencer emits one after the other from its single result register.
// Reset: arst_n clears the header state, the command queue and the result valid flag.
module ines_nrom_sram_loader import inrl_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input in_item_t item,
	output logic empty,
	input logic pop,
	output out_item_t result
);

	logic take;
	cmd_req_t req;
	cmd_t head;
	logic q_empty;
	logic q_pop;

	assign take = push && !full;

	inrl_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.take(take),
		.item(item),
		.req(req)
	);

	inrl_cmd_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.wr(req),
		.rd_en(q_pop),
		.rd_data(head),
		.empty(q_empty),
		.full(full)
	);

	inrl_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_empty(q_empty),
		.cmd(head),
		.cmd_pop(q_pop),
		.pop(pop),
		.empty(empty),
		.result(result)
	);

endmodule

@@ rtl/inrl_front.sv @@
`timescale 1ns / 1ps
// Front end of the loader: header parsing, phase tracking and command generation.
// Depends on inrl_pkg.
module inrl_front import inrl_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic take,
	input in_item_t item,
	output cmd_req_t req
);

	phase_t phase_q, phase_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic prg_two_q, prg_two_d;
	logic chr_q, chr_d;
	logic trainer_q, trainer_d;
	logic magic_bad_q, magic_bad_d;
	logic size_bad_q, size_bad_d;
	logic [CNT_W-1:0] prg_last;
	logic [7:0] b;

	assign b = item.image_byte;
	assign prg_last = prg_two_q ? CNT_W'(2 * BANK_PRG - 1) : CNT_W'(BANK_PRG - 1);

	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		prg_two_d = prg_two_q;
		chr_d = chr_q;
		trainer_d = trainer_q;
		magic_bad_d = magic_bad_q;
		size_bad_d = size_bad_q;
		if (take) begin
			if (item.kind == KIND_END) begin
				phase_d = PH_HEADER;
				count_d = '0;
				prg_two_d = 1'b0;
				chr_d = 1'b0;
				trainer_d = 1'b0;
				magic_bad_d = 1'b0;
				size_bad_d = 1'b0;
			end else begin
				unique case (phase_q)
					PH_HEADER: begin
						if (count_q < CNT_W'(4)) begin
							if (b != magic_byte(count_q[1:0])) magic_bad_d = 1'b1;
						end else if (count_q == CNT_W'(4)) begin
							prg_two_d = (b == 8'd2);
							if (b == 8'd0 || b > 8'(PRG_MAX_BANKS)) size_bad_d = 1'b1;
						end else if (count_q == CNT_W'(5)) begin
							chr_d = (b != 8'd0);
							if (b > 8'(CHR_MAX_BANKS)) size_bad_d = 1'b1;
						end else if (count_q == CNT_W'(6)) begin
							trainer_d = (b & TRAINER_FLAG) != 8'd0;
						end
						count_d = count_q + CNT_W'(1);
						if (count_q == CNT_W'(HEADER_LEN - 1)) begin
							count_d = '0;
							if (magic_bad_q || size_bad_q) phase_d = PH_REJECTED;
							else phase_d = trainer_q ? PH_TRAINER : PH_PRG;
						end
					end
					PH_TRAINER: begin
						count_d = count_q + CNT_W'(1);
						if (count_q == CNT_W'(TRAINER_LEN - 1)) begin
							count_d = '0;
							phase_d = PH_PRG;
						end
					end
					PH_PRG: begin
						count_d = count_q + CNT_W'(1);
						if (count_q == prg_last) begin
							count_d = '0;
							phase_d = chr_q ? PH_CHR : PH_TAIL;
						end
					end
					PH_CHR: begin
						count_d = count_q + CNT_W'(1);
						if (count_q == CNT_W'(BANK_CHR - 1)) begin
							count_d = '0;
							phase_d = PH_TAIL;
						end
					end
					PH_TAIL, PH_REJECTED: begin
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_comb begin
		req.valid = 1'b0;
		req.cmd.op = OP_WRITE;
		req.cmd.target = TGT_PRG;
		req.cmd.address = count_q;
		req.cmd.data = b;
		req.cmd.status = ST_OK;
		if (take) begin
			if (item.kind == KIND_END) begin
				req.valid = 1'b1;
				req.cmd.op = OP_STATUS;
				unique case (phase_q)
					PH_HEADER: req.cmd.status = ST_BAD_HEADER;
					PH_REJECTED: req.cmd.status = magic_bad_q ? ST_BAD_HEADER : ST_NOT_NROM;
					PH_TAIL: req.cmd.status = ST_OK;
					default: req.cmd.status = ST_TRUNCATED;
				endcase
			end else if (phase_q == PH_PRG) begin
				req.valid = 1'b1;
				req.cmd.op = (!prg_two_q && PRG_MIRROR) ? OP_MIRROR : OP_WRITE;
			end else if (phase_q == PH_CHR) begin
				req.valid = 1'b1;
				req.cmd.target = TGT_CHR;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			count_q <= '0;
			prg_two_q <= 1'b0;
			chr_q <= 1'b0;
			trainer_q <= 1'b0;
			magic_bad_q <= 1'b0;
			size_bad_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			count_q <= count_d;
			prg_two_q <= prg_two_d;
			chr_q <= chr_d;
			trainer_q <= trainer_d;
			magic_bad_q <= magic_bad_d;
			size_bad_q <= size_bad_d;
		end
	end

endmodule

@@ rtl/inrl_cmd_fifo.sv @@
`timescale 1ns / 1ps
// Short command queue between the front end and the write sequencer.
// Depends on inrl_pkg.
module inrl_cmd_fifo import inrl_pkg::*; (
	input logic clk,
	input logic arst_n,
	input cmd_req_t wr,
	input logic rd_en,
	output cmd_t rd_data,
	output logic empty,
	output logic full
);

	localparam int unsigned PTR_W = $clog2(CMD_DEPTH);
	localparam int unsigned CNT_FW = $clog2(CMD_DEPTH + 1);

	cmd_t mem_q [CMD_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_FW-1:0] fill_q;
	logic do_wr, do_rd;

	assign empty = (fill_q == '0);
	assign full = (fill_q == CNT_FW'(CMD_DEPTH));
	assign do_wr = wr.valid && !full;
	assign do_rd = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr.cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (do_rd) rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (do_wr && !do_rd) fill_q <= fill_q + CNT_FW'(1);
			else if (do_rd && !do_wr) fill_q <= fill_q - CNT_FW'(1);
		end
	end

endmodule

@@ rtl/inrl_back.sv @@
`timescale 1ns / 1ps
// Write sequencer: expands queued commands into SRAM write and status results.
// Depends on inrl_pkg.
module inrl_back import inrl_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cmd_empty,
	input cmd_t cmd,
	output logic cmd_pop,
	input logic pop,
	output logic empty,
	output out_item_t result
);

	logic half_q;
	logic out_valid_q;
	out_item_t result_q;
	out_item_t next_res;
	logic produce;
	logic first_half;

	assign produce = !cmd_empty && (!out_valid_q || pop);
	assign first_half = (cmd.op == OP_MIRROR) && !half_q;
	assign cmd_pop = produce && !first_half;
	assign empty = !out_valid_q;
	assign result = result_q;

	always_comb begin
		next_res.result_kind = RK_WRITE;
		next_res.target = cmd.target;
		next_res.address = cmd.address;
		next_res.write_data = cmd.data;
		next_res.status = ST_OK;
		next_res.last = 1'b1;
		unique case (cmd.op)
			OP_STATUS: begin
				next_res.result_kind = RK_STATUS;
				next_res.target = TGT_PRG;
				next_res.address = '0;
				next_res.write_data = '0;
				next_res.status = cmd.status;
			end
			OP_MIRROR: begin
				if (half_q) next_res.address = cmd.address + ADDR_W'(BANK_PRG);
				else next_res.last = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (produce) result_q <= next_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (produce) half_q <= first_half;
			if (produce) out_valid_q <= 1'b1;
			else if (pop) out_valid_q <= 1'b0;
		end
	end

endmodule

@@ rtl/inrl_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the loader, attached to the top level by bind.
// Depends on inrl_pkg and ines_nrom_sram_loader.
module inrl_checker import inrl_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic full,
	input in_item_t item,
	input logic empty,
	input logic pop,
	input out_item_t result
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("Result changed while waiting.");

	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.result_kind == RK_STATUS |->
		result.last && result.target == TGT_PRG && result.address == '0 &&
		result.write_data == '0)
		else $error("Status transaction carries write fields.");

	a_first_half: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !result.last |->
		result.result_kind == RK_WRITE && result.target == TGT_PRG && !result.address[14])
		else $error("Bad first half of a mirrored write.");

	a_mirror_pair: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !empty && !result.last |=>
		!empty && result.last && result.result_kind == RK_WRITE &&
		result.address == $past(result.address) + ADDR_W'(BANK_PRG) &&
		result.write_data == $past(result.write_data))
		else $error("Mirrored write pair broken.");

endmodule

bind ines_nrom_sram_loader inrl_checker u_checker (
	.clk(clk),
	.arst_n(arst_n),
	.push(push),
	.full(full),
	.item(item),
	.empty(empty),
	.pop(pop),
	.result(result)
);
